// File: hw/rtl/fpr_pkg.sv
package fpr_pkg;

	// Field widths of the result item
	localparam int RECORD_LENGTH_W = 40;
	localparam int LINE_NUMBER_W   = 32;

	// Default counter widths
	localparam int DEF_LENGTH_BITS = 40;
	localparam int DEF_LINE_BITS   = 32;

	// Characters
	localparam logic [7:0] SEPARATOR_CHAR = 8'h3E;
	localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
	localparam logic [7:0] SPACE_CHAR     = 8'h20;

	// Parse states
	localparam logic [2:0] ST_EXPECT   = 3'd0;
	localparam logic [2:0] ST_DESC     = 3'd1;
	localparam logic [2:0] ST_AFTER_NL = 3'd2;
	localparam logic [2:0] ST_SEQ      = 3'd3;
	localparam logic [2:0] ST_STOPPED  = 3'd4;

	// Input actions
	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// Result kinds
	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_DESC_BYTE = 3'd1;
	localparam logic [2:0] KIND_DESC_DONE = 3'd2;
	localparam logic [2:0] KIND_SEQ_BYTE  = 3'd3;
	localparam logic [2:0] KIND_RECORD    = 3'd4;
	localparam logic [2:0] KIND_ERROR     = 3'd5;

	// Error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_SEPARATOR  = 3'd1;
	localparam logic [2:0] ERR_EMPTY_SEQ  = 3'd2;
	localparam logic [2:0] ERR_EMPTY_FILE = 3'd3;
	localparam logic [2:0] ERR_UNFINISHED = 3'd4;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]                 kind;
		logic [7:0]                 out_byte;
		logic [RECORD_LENGTH_W-1:0] record_length;
		logic [LINE_NUMBER_W-1:0]   line_number;
		logic [2:0]                 error_code;
	} out_item_t;

endpackage

// File: hw/rtl/fpr_if.sv
interface fpr_in_if;
	import fpr_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface fpr_out_if;
	import fpr_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: hw/rtl/fpr_step.sv
module fpr_step #(
	parameter int LENGTH_BITS = fpr_pkg::DEF_LENGTH_BITS,
	parameter int LINE_BITS   = fpr_pkg::DEF_LINE_BITS
) (
	input  fpr_pkg::in_item_t       item,
	input  logic [2:0]              state,
	input  logic [LENGTH_BITS-1:0]  residue,
	input  logic [LINE_BITS-1:0]    line,
	output logic [2:0]              state_nxt,
	output logic [LENGTH_BITS-1:0]  residue_nxt,
	output logic [LINE_BITS-1:0]    line_nxt,
	output fpr_pkg::out_item_t      result
);
	import fpr_pkg::*;

	logic [LENGTH_BITS-1:0] residue_inc;
	logic [LINE_BITS-1:0]   line_inc;
	logic [LINE_BITS-1:0]   line_prev;
	logic                   residue_zero;
	logic                   is_nl;

	// Saturating counters
	assign residue_inc  = (residue == '1) ? residue : residue + LENGTH_BITS'(1);
	assign line_inc     = (line == '1) ? line : line + LINE_BITS'(1);
	assign line_prev    = (line == '0) ? '0 : line - LINE_BITS'(1);
	assign residue_zero = (residue == '0);
	assign is_nl        = (item.data_byte == NEWLINE_CHAR);

	always_comb begin
		state_nxt   = state;
		residue_nxt = residue;
		line_nxt    = line;
		result      = '0;

		if (item.action == ACT_END) begin
			unique case (state)
				ST_EXPECT: begin
					result.kind        = KIND_ERROR;
					result.line_number = LINE_NUMBER_W'(line);
					result.error_code  = ERR_EMPTY_FILE;
				end
				ST_DESC: begin
					result.kind        = KIND_ERROR;
					result.line_number = LINE_NUMBER_W'(line);
					result.error_code  = ERR_UNFINISHED;
				end
				ST_AFTER_NL, ST_SEQ: begin
					if (residue_zero) begin
						result.kind        = KIND_ERROR;
						result.line_number = LINE_NUMBER_W'(line_prev);
						result.error_code  = ERR_EMPTY_SEQ;
					end else begin
						result.kind          = KIND_RECORD;
						result.record_length = RECORD_LENGTH_W'(residue);
					end
				end
				default: begin
				end
			endcase
			// rewind to the start state
			state_nxt   = ST_EXPECT;
			residue_nxt = '0;
			line_nxt    = LINE_BITS'(1);
		end else begin
			unique case (state)
				ST_EXPECT: begin
					if (item.data_byte != SEPARATOR_CHAR) begin
						result.kind        = KIND_ERROR;
						result.line_number = LINE_NUMBER_W'(line);
						result.error_code  = ERR_SEPARATOR;
						state_nxt          = ST_STOPPED;
					end else begin
						state_nxt = ST_DESC;
					end
				end
				ST_DESC: begin
					if (is_nl) begin
						result.kind = KIND_DESC_DONE;
						residue_nxt = '0;
						line_nxt    = line_inc;
						state_nxt   = ST_AFTER_NL;
					end else begin
						result.kind     = KIND_DESC_BYTE;
						result.out_byte = item.data_byte;
					end
				end
				ST_AFTER_NL, ST_SEQ: begin
					if (state == ST_AFTER_NL && item.data_byte == SEPARATOR_CHAR) begin
						if (residue_zero) begin
							result.kind        = KIND_ERROR;
							result.line_number = LINE_NUMBER_W'(line_prev);
							result.error_code  = ERR_EMPTY_SEQ;
							state_nxt          = ST_STOPPED;
						end else begin
							result.kind          = KIND_RECORD;
							result.record_length = RECORD_LENGTH_W'(residue);
							state_nxt            = ST_DESC;
						end
					end else if (is_nl) begin
						line_nxt  = line_inc;
						state_nxt = ST_AFTER_NL;
					end else begin
						residue_nxt = residue_inc;
						if (item.data_byte != SPACE_CHAR) begin
							result.kind     = KIND_SEQ_BYTE;
							result.out_byte = item.data_byte;
						end
						state_nxt = ST_SEQ;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/fasta_record_parser.sv
// The result item of an accepted input item is registered in the output register.
// Throughput: one item per cycle while the sink takes results; state and both counters update
// per accepted item; the output register takes a new item while the previous result drains.
// Reset (arst_n low, asynchronous): state returns to expecting '>', residue count to zero,
// line count to one, and the output register is emptied.
module fasta_record_parser #(
	parameter int LENGTH_BITS = fpr_pkg::DEF_LENGTH_BITS,
	parameter int LINE_BITS   = fpr_pkg::DEF_LINE_BITS
) (
	input logic       clk,
	input logic       arst_n,
	fpr_in_if.sink    din,
	fpr_out_if.source dout
);
	import fpr_pkg::*;

	// Parse state and counters
	logic [2:0]             state_q;
	logic [LENGTH_BITS-1:0] residue_q;
	logic [LINE_BITS-1:0]   line_q;

	// Next values from the step logic
	logic [2:0]             state_nxt;
	logic [LENGTH_BITS-1:0] residue_nxt;
	logic [LINE_BITS-1:0]   line_nxt;
	out_item_t              result;

	// Output register
	logic      out_valid_q;
	out_item_t out_item_q;

	logic accept;

	// Take a new item whenever the output register is empty or is being drained
	// in this same cycle, so back-to-back items flow without a bubble.
	assign din.ready = !out_valid_q || dout.ready;
	assign accept    = din.valid && din.ready;

	fpr_step #(
		.LENGTH_BITS(LENGTH_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_step (
		.item       (din.payload),
		.state      (state_q),
		.residue    (residue_q),
		.line       (line_q),
		.state_nxt  (state_nxt),
		.residue_nxt(residue_nxt),
		.line_nxt   (line_nxt),
		.result     (result)
	);

	// Advance the parser state only on an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_EXPECT;
			residue_q <= '0;
			line_q    <= LINE_BITS'(1);
		end else if (accept) begin
			state_q   <= state_nxt;
			residue_q <= residue_nxt;
			line_q    <= line_nxt;
		end
	end

	// Every accepted item produces exactly one result item (kind none included).
	// Hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload register: no reset needed, qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q <= result;
		end
	end

	assign dout.valid   = out_valid_q;
	assign dout.payload = out_item_q;

endmodule

// File: tb/tb_fasta_record_parser.sv
`timescale 1ns / 1ps

module tb_fasta_record_parser;
	import fpr_pkg::*;

	// Counter widths of the parser under test
	localparam int CNT_LENGTH_BITS = 16;
	localparam int CNT_LINE_BITS   = 16;
	localparam logic [63:0] RESIDUE_MAX = (64'd1 << CNT_LENGTH_BITS) - 64'd1;
	localparam logic [63:0] LINE_MAX    = (64'd1 << CNT_LINE_BITS) - 64'd1;

	localparam int ITEM_TARGET     = 1300;
	localparam int CYCLE_LIMIT     = 2000000;
	localparam int DRAIN_CYCLES    = 5;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_PRINTED     = 40;

	logic clk;
	logic arst_n;

	fpr_in_if  din_if();
	fpr_out_if dout_if();

	fasta_record_parser #(
		.LENGTH_BITS(CNT_LENGTH_BITS),
		.LINE_BITS  (CNT_LINE_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if)
	);

	// Parser state as the predictor sees it
	logic [2:0]  fsm_state;
	logic [63:0] residues;
	logic [63:0] lines;

	out_item_t expected_results[$];

	int items_sent;
	int results_seen;
	int mismatch_count;
	int cycle_count;

	// Idle controls shared between the test tasks, the send task and the result-side ready process
	bit src_idle_on;
	bit sink_idle_on;
	int sink_hold_left;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Abort a hung run; the limit covers every item with its longest gap and stall
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_non_newline();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == NEWLINE_CHAR);
		return b;
	endfunction

	// Rewind the predicted parser to its start state
	function automatic void parse_rewind();
		fsm_state = ST_EXPECT;
		residues  = '0;
		lines     = 64'd1;
	endfunction

	function automatic out_item_t parse_error(logic [63:0] line, logic [2:0] code);
		out_item_t r;
		r             = '0;
		r.kind        = KIND_ERROR;
		r.line_number = line[LINE_NUMBER_W-1:0];
		r.error_code  = code;
		return r;
	endfunction

	function automatic out_item_t parse_record_done();
		out_item_t r;
		r               = '0;
		r.kind          = KIND_RECORD;
		r.record_length = residues[RECORD_LENGTH_W-1:0];
		return r;
	endfunction

	function automatic logic [63:0] desc_line();
		return (lines > 0) ? lines - 64'd1 : 64'd0;
	endfunction

	function automatic void bump_lines();
		if (lines < LINE_MAX)
			lines++;
	endfunction

	// Advance the predicted parser by one item and return the result it gives
	function automatic out_item_t parse_predict(in_item_t it);
		out_item_t r;
		r = '0;
		if (it.action == ACT_END) begin
			case (fsm_state)
				ST_EXPECT: r = parse_error(lines, ERR_EMPTY_FILE);
				ST_DESC:   r = parse_error(lines, ERR_UNFINISHED);
				ST_AFTER_NL, ST_SEQ: begin
					if (residues == 0)
						r = parse_error(desc_line(), ERR_EMPTY_SEQ);
					else
						r = parse_record_done();
				end
				default: ;
			endcase
			parse_rewind();
			return r;
		end
		case (fsm_state)
			ST_EXPECT: begin
				if (it.data_byte != SEPARATOR_CHAR) begin
					r         = parse_error(lines, ERR_SEPARATOR);
					fsm_state = ST_STOPPED;
				end else begin
					fsm_state = ST_DESC;
				end
			end
			ST_DESC: begin
				if (it.data_byte == NEWLINE_CHAR) begin
					r.kind    = KIND_DESC_DONE;
					residues  = '0;
					bump_lines();
					fsm_state = ST_AFTER_NL;
				end else begin
					r.kind     = KIND_DESC_BYTE;
					r.out_byte = it.data_byte;
				end
			end
			ST_AFTER_NL, ST_SEQ: begin
				if (fsm_state == ST_AFTER_NL && it.data_byte == SEPARATOR_CHAR) begin
					// A '>' at the start of a line closes the record
					if (residues == 0) begin
						r         = parse_error(desc_line(), ERR_EMPTY_SEQ);
						fsm_state = ST_STOPPED;
					end else begin
						r         = parse_record_done();
						fsm_state = ST_DESC;
					end
				end else if (it.data_byte == NEWLINE_CHAR) begin
					bump_lines();
					fsm_state = ST_AFTER_NL;
				end else begin
					// Count every residue, spaces too, but pass out only non-spaces
					if (residues < RESIDUE_MAX)
						residues++;
					if (it.data_byte != SPACE_CHAR) begin
						r.kind     = KIND_SEQ_BYTE;
						r.out_byte = it.data_byte;
					end
					fsm_state = ST_SEQ;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// Offer one item and hold it until the parser takes it; predict on acceptance.
	// Valid stays high across back-to-back items and drops only for a gap.
	task automatic send_item(in_item_t it);
		int gap;
		gap = src_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid   <= 1'b1;
		din_if.payload <= it;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		expected_results.push_back(parse_predict(it));
		items_sent++;
	endtask

	task automatic send_data(logic [7:0] b);
		in_item_t it;
		it.action    = ACT_DATA;
		it.data_byte = b;
		send_item(it);
	endtask

	task automatic send_end(logic [7:0] junk);
		in_item_t it;
		it.action    = ACT_END;
		it.data_byte = junk;
		send_item(it);
	endtask

	task automatic send_description();
		int n;
		n = $urandom_range(0, 6);
		send_data(SEPARATOR_CHAR);
		repeat (n) send_data(rand_non_newline());
	endtask

	// One sequence line: mostly nucleotides, now and then a space or any other byte
	task automatic send_sequence_line();
		int n;
		int r;
		logic [7:0] b;
		n = $urandom_range(1, 12);
		repeat (n) begin
			r = $urandom_range(0, 19);
			case (r)
				0, 1:    b = SPACE_CHAR;
				2, 3:    b = rand_non_newline();
				default: begin
					case ($urandom_range(0, 4))
						0:       b = "A";
						1:       b = "C";
						2:       b = "G";
						3:       b = "T";
						default: b = "N";
					endcase
				end
			endcase
			send_data(b);
		end
	endtask

	// A well-formed file with random content; broken files stop in the header
	// or carry an empty record.
	task automatic send_fasta_file(bit broken);
		int n_records;
		int n_lines;
		n_records = $urandom_range(1, 3);
		for (int rec = 0; rec < n_records; rec++) begin
			send_description();
			if (broken && $urandom_range(0, 2) == 0) begin
				send_end(8'($urandom_range(0, 255)));
				return;
			end
			send_data(NEWLINE_CHAR);
			n_lines = (broken && $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
			for (int ln = 0; ln < n_lines; ln++) begin
				if ($urandom_range(0, 9) == 0)
					send_data(NEWLINE_CHAR);
				send_sequence_line();
				// The last line of the file may lack its newline
				if (ln < n_lines - 1 || rec < n_records - 1 || $urandom_range(0, 1) == 0)
					send_data(NEWLINE_CHAR);
			end
		end
		send_end(8'($urandom_range(0, 255)));
	endtask

	// Raw bytes, mostly garbage, then rewind with end of input
	task automatic send_noise_burst();
		int n;
		n = $urandom_range(1, 20);
		repeat (n) begin
			case ($urandom_range(0, 11))
				0:       send_end(8'($urandom_range(0, 255)));
				1:       send_data(SEPARATOR_CHAR);
				2:       send_data(NEWLINE_CHAR);
				default: send_data(8'($urandom_range(0, 255)));
			endcase
		end
		send_end(8'($urandom_range(0, 255)));
	endtask

	// Result checker: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			got = dout_if.payload;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d", got.kind));
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind)
					report_mismatch($sformatf("result %0d kind got %0d want %0d",
						results_seen, got.kind, want.kind));
				if (got.out_byte !== want.out_byte)
					report_mismatch($sformatf("result %0d out_byte got %0h want %0h",
						results_seen, got.out_byte, want.out_byte));
				if (got.record_length !== want.record_length)
					report_mismatch($sformatf("result %0d record_length got %0d want %0d",
						results_seen, got.record_length, want.record_length));
				if (got.line_number !== want.line_number)
					report_mismatch($sformatf("result %0d line_number got %0d want %0d",
						results_seen, got.line_number, want.line_number));
				if (got.error_code !== want.error_code)
					report_mismatch($sformatf("result %0d error_code got %0d want %0d",
						results_seen, got.error_code, want.error_code));
			end
			results_seen++;
		end
	end

	// Result side ready: a requested hold-off first, then random stalls
	initial begin
		int stall_left;
		stall_left = 0;
		dout_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				dout_if.ready <= 1'b0;
			end else if (sink_hold_left > 0) begin
				dout_if.ready <= 1'b0;
				sink_hold_left--;
			end else if (stall_left > 0) begin
				dout_if.ready <= 1'b0;
				stall_left--;
			end else begin
				dout_if.ready <= 1'b1;
				if (sink_idle_on && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Short hand-picked streams covering every result kind and error
	task automatic test_directed();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		// Empty file: end of input before anything else
		send_end(8'h00);
		// Missing separator, then ignored bytes and a silent end
		send_data("A");
		send_data(8'hFF);
		send_end(SEPARATOR_CHAR);
		// Extreme description bytes, then end inside the description
		send_data(SEPARATOR_CHAR);
		send_data(8'h00);
		send_data(8'hFF);
		send_end(NEWLINE_CHAR);
		// Empty sequence closed by the next header
		send_data(SEPARATOR_CHAR);
		send_data(NEWLINE_CHAR);
		send_data(NEWLINE_CHAR);
		send_data(SEPARATOR_CHAR);
		send_end(8'h00);
		// Space and mid-line '>' count as residues; record closed by a header,
		// then an empty record at end of input
		send_data(SEPARATOR_CHAR);
		send_data("h");
		send_data(NEWLINE_CHAR);
		send_data("A");
		send_data(SPACE_CHAR);
		send_data(SEPARATOR_CHAR);
		send_data(NEWLINE_CHAR);
		send_data(SEPARATOR_CHAR);
		send_data(NEWLINE_CHAR);
		send_end(8'hFF);
		// Record finished by end of input in mid-line
		send_data(SEPARATOR_CHAR);
		send_data(NEWLINE_CHAR);
		send_data("C");
		send_end(8'h55);
	endtask

	// Mostly well-formed files, with broken files and raw noise mixed in
	task automatic test_random_records();
		int r;
		while (items_sent < ITEM_TARGET) begin
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 9);
			if (r < 7)
				send_fasta_file(1'b0);
			else if (r < 9)
				send_fasta_file(1'b1);
			else
				send_noise_burst();
		end
	endtask

	// Hold the result side off while items keep coming so the input stalls
	task automatic test_backpressure();
		src_idle_on    = 1'b0;
		sink_idle_on   = 1'b0;
		sink_hold_left = HOLD_OFF_CYCLES;
		repeat (4) send_fasta_file(1'b0);
	endtask

	initial begin
		arst_n         = 1'b0;
		din_if.valid   <= 1'b0;
		din_if.payload <= '0;
		items_sent     = 0;
		results_seen   = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		sink_hold_left = 0;
		src_idle_on    = 1'b0;
		sink_idle_on   = 1'b0;
		parse_rewind();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_records();
		test_backpressure();
		test_random_records();

		// Drop valid in the step of the last acceptance, then drain
		din_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: fasta_record_parser.f
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_if.sv
hw/rtl/fpr_step.sv
hw/rtl/fasta_record_parser.sv
tb/tb_fasta_record_parser.sv
